[rtl/per_cpu_period_sorted_task_queue_defines.svh]
// Assertion macros shared by the task queue RTL.
// Needs clk and rst_n in scope at the place of use.
`ifndef PER_CPU_PERIOD_SORTED_TASK_QUEUE_DEFINES_SVH
`define PER_CPU_PERIOD_SORTED_TASK_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every edge outside reset
`define PCQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must hold in the cycle after a trigger
`define PCQ_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define PCQ_ASSERT(label, prop, msg)
`define PCQ_ASSERT_NEXT(label, trig, cond, msg)
`endif

`endif

[rtl/pcq_pkg.sv]
// Package for the per-CPU period-sorted task queue.
// Sizes, codes, entry and control types used by all pcq modules.
package pcq_pkg;

    localparam int NUM_CPUS   = 4;
    localparam int LIST_DEPTH = 16;

    localparam int OPCODE_W = 2;
    localparam int CPU_W    = 2;
    localparam int TASK_W   = 16;
    localparam int PERIOD_W = 48;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int ENTRIES = NUM_CPUS * LIST_DEPTH;
    localparam int CSEL_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int IDX_W   = $clog2(LIST_DEPTH);
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE      = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS_RD,
        S_INS_EV,
        S_DEL_RD,
        S_DEL_EV,
        S_HEAD_RD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TASK_W-1:0]   task_id;
    } entry_t;

    // sequencer -> store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic [CSEL_W-1:0] cpu_sel;
        logic              len_we;
        logic [CNT_W-1:0]  len_value;
        logic              clear;
    } ctl_t;

    // compare unit -> sequencer
    typedef struct packed {
        logic period_gt;
        logic task_eq;
    } cmp_t;

    // sequencer -> output register
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   head_task;
        logic                head_valid;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CSEL_W-1:0] c,
                                                  input logic [IDX_W-1:0]  i);
        return ADDR_W'(int'(c) * LIST_DEPTH + int'(i));
    endfunction

endpackage

[rtl/pcq_store.sv]
// Entry memory (all CPU lists, list-major) and per-CPU length registers.
// Depends on pcq_pkg.
module pcq_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcq_pkg::ctl_t                 ctl,
    output pcq_pkg::entry_t               rd_data,
    output logic [pcq_pkg::CNT_W-1:0]     cur_len
);
    import pcq_pkg::*;

    entry_t           mem [ENTRIES];
    entry_t           rd_data_reg;
    logic [CNT_W-1:0] len_reg [NUM_CPUS];

    // entries past a list's length are never read, so no clear pass
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (ctl.len_we)
        begin
            len_reg[ctl.cpu_sel] <= ctl.len_value;
        end
    end

    always_comb
    begin
        if (int'(ctl.cpu_sel) < NUM_CPUS)
        begin
            cur_len = len_reg[ctl.cpu_sel];
        end
        else
        begin
            cur_len = '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/pcq_cmp.sv]
// Shared compare unit: period order and task id match for one stored entry.
// Depends on pcq_pkg.
module pcq_cmp (
    input  pcq_pkg::entry_t                 entry,
    input  logic [pcq_pkg::PERIOD_W-1:0]    key_period,
    input  logic [pcq_pkg::TASK_W-1:0]      key_task,
    output pcq_pkg::cmp_t                   result
);
    import pcq_pkg::*;

    always_comb
    begin
        result.period_gt = entry.period > key_period;
        result.task_eq   = entry.task_id == key_task;
    end

endmodule

[rtl/pcq_seq.sv]
// Sequencer: walks one CPU list an entry at a time for insert and delete.
// Depends on pcq_pkg; drives pcq_store and reads the pcq_cmp result.
`include "per_cpu_period_sorted_task_queue_defines.svh"
module pcq_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_fire,
    input  logic [pcq_pkg::OPCODE_W-1:0]    opcode,
    input  logic [pcq_pkg::CPU_W-1:0]       cpu,
    input  logic [pcq_pkg::TASK_W-1:0]      task_id,
    input  logic [pcq_pkg::PERIOD_W-1:0]    period_ns,
    input  logic                            out_free,
    input  pcq_pkg::entry_t                 rd_data,
    input  logic [pcq_pkg::CNT_W-1:0]       cur_len,
    input  pcq_pkg::cmp_t                   cmp,
    output logic                            idle,
    output logic [pcq_pkg::PERIOD_W-1:0]    key_period,
    output logic [pcq_pkg::TASK_W-1:0]      key_task,
    output pcq_pkg::ctl_t                   ctl,
    output pcq_pkg::rsp_t                   rsp
);
    import pcq_pkg::*;

    state_t              state_reg, state_next;
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [CSEL_W-1:0]   cpu_reg, cpu_next;
    logic                in_range_reg, in_range_next;
    logic [TASK_W-1:0]   task_reg, task_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [CNT_W-1:0]    idx_m1;
    logic                list_full;
    logic                head_ok;
    entry_t              new_entry;

    assign idx_m1     = idx_reg - CNT_W'(1);
    assign list_full  = cur_len >= CNT_W'(LIST_DEPTH);
    assign head_ok    = in_range_reg && (cur_len != '0);
    assign new_entry  = '{period: period_reg, task_id: task_reg};
    assign key_period = period_reg;
    assign key_task   = task_reg;
    assign idle       = state_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            status_reg   <= STS_DONE;
            in_range_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            status_reg   <= status_next;
            in_range_reg <= in_range_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cpu_reg    <= cpu_next;
        task_reg   <= task_next;
        period_reg <= period_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        state_next = (!in_range_reg || list_full) ? S_HEAD_RD : S_INS_RD;
                    end
                    OP_DELETE:
                    begin
                        state_next = in_range_reg ? S_DEL_RD : S_HEAD_RD;
                    end
                    default:
                    begin
                        state_next = S_HEAD_RD;
                    end
                endcase
            end
            S_INS_RD:
            begin
                state_next = (idx_reg == '0) ? S_HEAD_RD : S_INS_EV;
            end
            S_INS_EV:
            begin
                state_next = cmp.period_gt ? S_INS_RD : S_HEAD_RD;
            end
            S_DEL_RD:
            begin
                state_next = (idx_reg == cur_len) ? S_HEAD_RD : S_DEL_EV;
            end
            S_DEL_EV:
            begin
                state_next = S_DEL_RD;
            end
            S_HEAD_RD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // store control and response
    always_comb
    begin
        ctl         = '0;
        ctl.cpu_sel = cpu_reg;
        rsp         = '0;
        case (state_reg)
            S_START:
            begin
                ctl.clear = op_reg == OP_CLEAR;
            end
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    ctl.wr_en     = 1'b1;
                    ctl.wr_addr   = addr_of(cpu_reg, '0);
                    ctl.wr_data   = new_entry;
                    ctl.len_we    = 1'b1;
                    ctl.len_value = cur_len + CNT_W'(1);
                end
                else
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_addr = addr_of(cpu_reg, idx_m1[IDX_W-1:0]);
                end
            end
            S_INS_EV:
            begin
                // larger period moves up one slot; otherwise the new task lands here
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = addr_of(cpu_reg, idx_reg[IDX_W-1:0]);
                if (cmp.period_gt)
                begin
                    ctl.wr_data = rd_data;
                end
                else
                begin
                    ctl.wr_data   = new_entry;
                    ctl.len_we    = 1'b1;
                    ctl.len_value = cur_len + CNT_W'(1);
                end
            end
            S_DEL_RD:
            begin
                if (idx_reg == cur_len)
                begin
                    ctl.len_we    = found_reg;
                    ctl.len_value = cur_len - CNT_W'(1);
                end
                else
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_addr = addr_of(cpu_reg, idx_reg[IDX_W-1:0]);
                end
            end
            S_DEL_EV:
            begin
                // entries after the removed one shift down
                if (found_reg)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_addr = addr_of(cpu_reg, idx_m1[IDX_W-1:0]);
                    ctl.wr_data = rd_data;
                end
            end
            S_HEAD_RD:
            begin
                if (head_ok)
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_addr = addr_of(cpu_reg, '0);
                end
            end
            S_DONE:
            begin
                rsp.valid       = out_free;
                rsp.status      = status_reg;
                rsp.head_valid  = head_ok;
                rsp.head_task   = head_ok ? rd_data.task_id : '0;
                rsp.entry_count = head_ok ? COUNT_W'(cur_len) : '0;
            end
            default:
            begin
                ctl.clear = 1'b0;
            end
        endcase
    end

    // request and walk registers
    always_comb
    begin
        op_next       = op_reg;
        cpu_next      = cpu_reg;
        in_range_next = in_range_reg;
        task_next     = task_reg;
        period_next   = period_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next       = opcode;
                    cpu_next      = CSEL_W'(cpu);
                    in_range_next = int'(cpu) < NUM_CPUS;
                    task_next     = task_id;
                    period_next   = period_ns;
                    idx_next      = '0;
                    found_next    = 1'b0;
                    status_next   = STS_DONE;
                end
            end
            S_START:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!in_range_reg || list_full)
                        begin
                            status_next = STS_FULL;
                        end
                        else
                        begin
                            idx_next = cur_len;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!in_range_reg)
                        begin
                            status_next = STS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        status_next = STS_DONE;
                    end
                endcase
            end
            S_INS_EV:
            begin
                if (cmp.period_gt)
                begin
                    idx_next = idx_m1;
                end
            end
            S_DEL_RD:
            begin
                if (idx_reg == cur_len && !found_reg)
                begin
                    status_next = STS_NOT_FOUND;
                end
            end
            S_DEL_EV:
            begin
                if (!found_reg && cmp.task_eq)
                begin
                    found_next = 1'b1;
                end
                idx_next = idx_reg + CNT_W'(1);
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    `PCQ_ASSERT(idx_in_range, idx_reg <= CNT_W'(LIST_DEPTH), "walk index past list depth")
    `PCQ_ASSERT_NEXT(start_after_accept, req_fire, state_reg == S_START, "accept outside idle")
    `PCQ_ASSERT(len_bounded, !ctl.len_we || ctl.len_value <= CNT_W'(LIST_DEPTH),
        "list length written beyond depth")
    `PCQ_ASSERT(no_write_on_reject,
        !(state_reg == S_DONE && status_reg == STS_FULL) || !ctl.wr_en,
        "store written for a rejected insert")

endmodule

[rtl/per_cpu_period_sorted_task_queue.sv]
// Per-CPU period-sorted task queue; one request at a time, result registered.
// Steps after acceptance: start; insert walks a read and an evaluate state per
// entry compared from the tail, delete one such pair per entry on the list; then
// head read and done. Clear, no-op and rejected requests skip the walk.
// A new request is taken only once the result has moved into the output register.
// Reset zeroes the per-CPU list lengths at once; the entry memory is not cleared.
`include "per_cpu_period_sorted_task_queue_defines.svh"
module per_cpu_period_sorted_task_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [pcq_pkg::OPCODE_W-1:0]    opcode,
    input  logic [pcq_pkg::CPU_W-1:0]       cpu,
    input  logic [pcq_pkg::TASK_W-1:0]      task_id,
    input  logic [pcq_pkg::PERIOD_W-1:0]    period_ns,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [pcq_pkg::STATUS_W-1:0]    status,
    output logic [pcq_pkg::TASK_W-1:0]      head_task,
    output logic                            head_valid,
    output logic [pcq_pkg::COUNT_W-1:0]     entry_count
);
    import pcq_pkg::*;

    ctl_t                ctl;
    rsp_t                seq_rsp;
    cmp_t                cmp;
    entry_t              rd_data;
    logic [CNT_W-1:0]    cur_len;
    logic [PERIOD_W-1:0] key_period;
    logic [TASK_W-1:0]   key_task;
    logic                seq_idle;
    logic                out_free;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TASK_W-1:0]   head_task_reg, head_task_next;
    logic                head_valid_reg, head_valid_next;
    logic [COUNT_W-1:0]  entry_count_reg, entry_count_next;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = seq_idle;

    pcq_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_fire   (req_valid && req_ready),
        .opcode     (opcode),
        .cpu        (cpu),
        .task_id    (task_id),
        .period_ns  (period_ns),
        .out_free   (out_free),
        .rd_data    (rd_data),
        .cur_len    (cur_len),
        .cmp        (cmp),
        .idle       (seq_idle),
        .key_period (key_period),
        .key_task   (key_task),
        .ctl        (ctl),
        .rsp        (seq_rsp)
    );

    pcq_cmp u_cmp (
        .entry      (rd_data),
        .key_period (key_period),
        .key_task   (key_task),
        .result     (cmp)
    );

    pcq_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_data (rd_data),
        .cur_len (cur_len)
    );

    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        status_next      = status_reg;
        head_task_next   = head_task_reg;
        head_valid_next  = head_valid_reg;
        entry_count_next = entry_count_reg;
        if (seq_rsp.valid)
        begin
            rsp_valid_next   = 1'b1;
            status_next      = seq_rsp.status;
            head_task_next   = seq_rsp.head_task;
            head_valid_next  = seq_rsp.head_valid;
            entry_count_next = seq_rsp.entry_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        head_task_reg   <= head_task_next;
        head_valid_reg  <= head_valid_next;
        entry_count_reg <= entry_count_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign head_task   = head_task_reg;
    assign head_valid  = head_valid_reg;
    assign entry_count = entry_count_reg;

    `PCQ_ASSERT(no_overwrite, !seq_rsp.valid || out_free, "result overwrites a pending one")
    `PCQ_ASSERT_NEXT(one_result_per_request, req_valid && req_ready, !seq_rsp.valid,
        "result issued in the cycle after acceptance")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the per-CPU period-sorted task queue.
// Depends on pcq_pkg and the per_cpu_period_sorted_task_queue RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcq_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 331;
    localparam int MODE_ITEMS   = 150;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   head_task;
        logic                head_valid;
        logic [COUNT_W-1:0]  entry_count;
    } queue_result_t;

    class task_queue_scoreboard;
        logic [PERIOD_W-1:0] slot_period [NUM_CPUS][LIST_DEPTH];
        logic [TASK_W-1:0]   slot_task   [NUM_CPUS][LIST_DEPTH];
        int                  slot_count  [NUM_CPUS];
        queue_result_t       pending_results [$];
        int                  errors;

        function new();
            foreach (slot_count[i])
                slot_count[i] = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // updates the lists for one request and returns its status
        function logic [STATUS_W-1:0] apply_request(logic [OPCODE_W-1:0] op, int c,
                                                    logic [TASK_W-1:0] tid,
                                                    logic [PERIOD_W-1:0] per);
            int n;
            int pos;
            int k;
            n   = slot_count[c];
            pos = 0;
            case (op)
                OP_CLEAR:
                begin
                    foreach (slot_count[i])
                        slot_count[i] = 0;
                    return STS_DONE;
                end
                OP_INSERT:
                begin
                    if (n >= LIST_DEPTH)
                        return STS_FULL;
                    // equal periods stay in arrival order
                    while (pos < n && slot_period[c][pos] <= per)
                        pos++;
                    for (k = n; k > pos; k--)
                    begin
                        slot_period[c][k] = slot_period[c][k-1];
                        slot_task[c][k]   = slot_task[c][k-1];
                    end
                    slot_period[c][pos] = per;
                    slot_task[c][pos]   = tid;
                    slot_count[c]       = n + 1;
                    return STS_DONE;
                end
                OP_DELETE:
                begin
                    while (pos < n && slot_task[c][pos] != tid)
                        pos++;
                    if (pos >= n)
                        return STS_NOT_FOUND;
                    for (k = pos; k + 1 < n; k++)
                    begin
                        slot_period[c][k] = slot_period[c][k+1];
                        slot_task[c][k]   = slot_task[c][k+1];
                    end
                    slot_count[c] = n - 1;
                    return STS_DONE;
                end
                default:
                    return STS_DONE;
            endcase
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic [CPU_W-1:0] cpu_idx,
                                   logic [TASK_W-1:0] tid, logic [PERIOD_W-1:0] per);
            queue_result_t r;
            int c;
            c = int'(cpu_idx);
            r.status = apply_request(op, c, tid, per);
            if (slot_count[c] > 0)
            begin
                r.head_task   = slot_task[c][0];
                r.head_valid  = 1'b1;
                r.entry_count = COUNT_W'(slot_count[c]);
            end
            else
            begin
                r.head_task   = '0;
                r.head_valid  = 1'b0;
                r.entry_count = '0;
            end
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [TASK_W-1:0] head,
                          logic hv, logic [COUNT_W-1:0] cnt);
            queue_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request pending");
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", st, want.status));
            if (head !== want.head_task)
                report_mismatch($sformatf("head_task %h, want %h", head, want.head_task));
            if (hv !== want.head_valid)
                report_mismatch($sformatf("head_valid %b, want %b", hv, want.head_valid));
            if (cnt !== want.entry_count)
                report_mismatch($sformatf("entry_count %0d, want %0d", cnt,
                                          want.entry_count));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CPU_W-1:0]    cpu;
    logic [TASK_W-1:0]   task_id;
    logic [PERIOD_W-1:0] period_ns;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   head_task;
    logic                head_valid;
    logic [COUNT_W-1:0]  entry_count;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    task_queue_scoreboard sb = new();

    per_cpu_period_sorted_task_queue u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            sb.note_request(opcode, cpu, task_id, period_ns);
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(status, head_task, head_valid, entry_count);
    end

    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [CPU_W-1:0] c,
                                input logic [TASK_W-1:0] tid,
                                input logic [PERIOD_W-1:0] per);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        cpu       <= c;
        task_id   <= tid;
        period_ns <= per;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // small id pool so deletes hit and duplicates occur; small periods for ties
    task automatic random_request(input int insert_pct);
        logic [OPCODE_W-1:0] op;
        logic [TASK_W-1:0]   tid;
        logic [PERIOD_W-1:0] per;
        int                  pick;
        pick = $urandom_range(199);
        if (pick == 0)
            op = OP_CLEAR;
        else if (pick < 7)
            op = OP_UNUSED;
        else if ($urandom_range(99) < insert_pct)
            op = OP_INSERT;
        else
            op = OP_DELETE;
        tid  = ($urandom_range(3) != 0) ? TASK_W'($urandom_range(15)) : TASK_W'($urandom);
        pick = $urandom_range(9);
        if (pick < 4)
            per = PERIOD_W'($urandom_range(7));
        else if (pick == 4)
            per = '1;
        else
            per = PERIOD_W'({$urandom, $urandom});
        send_request(op, CPU_W'($urandom_range(NUM_CPUS - 1)), tid, per);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        opcode    = OP_INSERT;
        cpu       = '0;
        task_id   = '0;
        period_ns = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_request(OP_DELETE, 2'd0, 16'h0001, '0);
        send_request(OP_INSERT, 2'd0, 16'hFFFF, '1);
        send_request(OP_INSERT, 2'd0, 16'h0000, '0);
        send_request(OP_INSERT, 2'd0, 16'h0005, '0);
        send_request(OP_INSERT, 2'd0, 16'h0005, 48'd100);
        send_request(OP_DELETE, 2'd0, 16'h0005, '0);
        send_request(OP_UNUSED, 2'd0, 16'h0000, '0);
        // fill cpu 3 with falling periods in tied pairs, then overflow it
        for (int k = 0; k < LIST_DEPTH; k++)
            send_request(OP_INSERT, 2'd3, TASK_W'(16'h0100 + k), PERIOD_W'(500 - (k / 2) * 10));
        send_request(OP_INSERT, 2'd3, 16'h0200, 48'd1);
        send_request(OP_DELETE, 2'd3, 16'h1234, '0);
        send_request(OP_CLEAR, 2'd1, 16'h0000, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                    hold_asks++;
                end
                1:
                begin
                    send_idle_pct = 79;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct = 19;
                    rsp_stall_pct = 19;
                end
            endcase
            // alternate fill-heavy and drain-heavy stretches
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_request(((i / MODE_ITEMS) % 2 == 0) ? 75 : 25);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        rsp_stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("per_cpu_period_sorted_task_queue test passed");
        else
            $display("per_cpu_period_sorted_task_queue test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("per_cpu_period_sorted_task_queue test failed");
        $finish;
    end

endmodule
